>>> design/tlcd_pkg.sv
// shared types and constants of the token loop collapse detector
package tlcd_pkg;

  localparam int TOKEN_BITS     = 20;
  localparam int MAX_WINDOW_DEF = 64;
  localparam int WINDOW_BITS    = 7;
  localparam int HITS_BITS      = 16;
  localparam int CFG_DATA_BITS  = 16;
  localparam int CFG_IDX_BITS   = 1;

  localparam logic [CFG_IDX_BITS-1:0] REG_WINDOW   = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_PATIENCE = 1'b1;

  localparam logic [1:0] DISTINCT_MANY = 2'd3;

  typedef struct packed {
    logic [TOKEN_BITS-1:0] token_id;
    logic                  sequence_start;
  } in_word_t;

  typedef struct packed {
    logic                 stop;
    logic [1:0]           distinct_seen;
    logic                 window_checked;
    logic [HITS_BITS-1:0] hits;
  } out_word_t;

  typedef struct packed {
    logic accept;
    logic issue_read;
    logic load_out;
  } ctrl_cmd_t;

  typedef struct packed {
    logic checked;
    logic last_read;
  } ctrl_sts_t;

endpackage

>>> design/tlcd_datapath.sv
// history memory, scan compare, hit counter and result register
module tlcd_datapath #(
  parameter int MAX_WINDOW = tlcd_pkg::MAX_WINDOW_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 cfg_we_i,
  input  logic [tlcd_pkg::CFG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [tlcd_pkg::CFG_DATA_BITS-1:0]   cfg_data_i,
  input  tlcd_pkg::in_word_t                   in_word_i,
  input  tlcd_pkg::ctrl_cmd_t                  cmd_i,
  output tlcd_pkg::ctrl_sts_t                  sts_o,
  output tlcd_pkg::out_word_t                  out_word_o
);

  localparam int PTR_W = $clog2(MAX_WINDOW);
  localparam int CNT_W = $clog2(MAX_WINDOW + 1);
  localparam int SAT_W = (CNT_W > tlcd_pkg::WINDOW_BITS) ? CNT_W : tlcd_pkg::WINDOW_BITS;
  localparam int TB    = tlcd_pkg::TOKEN_BITS;
  localparam int HB    = tlcd_pkg::HITS_BITS;

  logic [TB-1:0] mem [MAX_WINDOW];

  logic [tlcd_pkg::WINDOW_BITS-1:0] window_q;
  logic [HB-1:0]                    patience_q;
  logic [PTR_W-1:0]                 wp_q, wp_d;
  logic [CNT_W-1:0]                 fill_q, fill_d;
  logic [HB-1:0]                    hits_q, hits_d;
  logic [PTR_W-1:0]                 rd_addr_q, rd_addr_d;
  logic [CNT_W-1:0]                 remain_q, remain_d;
  logic                             checked_q, checked_d;
  logic                             rd_vld_q;
  logic [TB-1:0]                    rd_data_q;
  logic [1:0]                       uniq_q, uniq_d;
  logic [TB-1:0]                    first_q, first_d;
  logic [TB-1:0]                    second_q, second_d;
  tlcd_pkg::out_word_t              out_q;

  logic [PTR_W-1:0] wp_eff, wp_next;
  logic [CNT_W-1:0] fill_eff, fill_next, w_sat;
  logic [SAT_W-1:0] win_ext, w_sat_wide;
  logic [PTR_W:0]   base_sum;
  logic [HB-1:0]    hits_eff, hits_new;

  // effective window, saturated at the ring depth
  always_comb begin
    win_ext    = SAT_W'(window_q);
    w_sat_wide = (win_ext > SAT_W'(MAX_WINDOW)) ? SAT_W'(MAX_WINDOW) : win_ext;
    w_sat      = CNT_W'(w_sat_wide);
  end

  always_comb begin
    wp_eff    = in_word_i.sequence_start ? '0 : wp_q;
    fill_eff  = in_word_i.sequence_start ? '0 : fill_q;
    hits_eff  = in_word_i.sequence_start ? '0 : hits_q;
    wp_next   = (wp_eff == PTR_W'(MAX_WINDOW - 1)) ? '0 : wp_eff + PTR_W'(1);
    fill_next = (fill_eff < CNT_W'(MAX_WINDOW)) ? fill_eff + CNT_W'(1) : fill_eff;
    // oldest entry of the window, one compare and subtract for the wrap
    base_sum  = {1'b0, wp_next} + (PTR_W + 1)'(MAX_WINDOW) - (PTR_W + 1)'(w_sat);
    if (base_sum >= (PTR_W + 1)'(MAX_WINDOW)) begin
      base_sum = base_sum - (PTR_W + 1)'(MAX_WINDOW);
    end
    checked_d = (w_sat != '0) && (patience_q != '0) && (fill_next >= w_sat);
  end

  always_comb begin
    hits_new = hits_q;
    if (checked_q) begin
      if (uniq_q == tlcd_pkg::DISTINCT_MANY) begin
        hits_new = '0;
      end else if (hits_q != {HB{1'b1}}) begin
        hits_new = hits_q + HB'(1);
      end
    end
  end

  always_comb begin
    wp_d      = wp_q;
    fill_d    = fill_q;
    hits_d    = hits_q;
    rd_addr_d = rd_addr_q;
    remain_d  = remain_q;
    if (cmd_i.accept) begin
      wp_d      = wp_next;
      fill_d    = fill_next;
      hits_d    = hits_eff;
      rd_addr_d = base_sum[PTR_W-1:0];
      remain_d  = w_sat;
    end else if (cmd_i.issue_read) begin
      rd_addr_d = (rd_addr_q == PTR_W'(MAX_WINDOW - 1)) ? '0 : rd_addr_q + PTR_W'(1);
      remain_d  = remain_q - CNT_W'(1);
    end else if (cmd_i.load_out) begin
      hits_d = hits_new;
    end
  end

  // distinct tracking, capped at three
  always_comb begin
    uniq_d   = uniq_q;
    first_d  = first_q;
    second_d = second_q;
    if (cmd_i.accept) begin
      uniq_d = '0;
    end else if (rd_vld_q) begin
      if (uniq_q == 2'd0) begin
        first_d = rd_data_q;
        uniq_d  = 2'd1;
      end else if (rd_data_q == first_q) begin
        uniq_d = uniq_q;
      end else if (uniq_q == 2'd1) begin
        second_d = rd_data_q;
        uniq_d   = 2'd2;
      end else if (uniq_q == 2'd2 && rd_data_q != second_q) begin
        uniq_d = tlcd_pkg::DISTINCT_MANY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      window_q   <= '0;
      patience_q <= '0;
      wp_q       <= '0;
      fill_q     <= '0;
      hits_q     <= '0;
      remain_q   <= '0;
      checked_q  <= 1'b0;
      rd_vld_q   <= 1'b0;
      uniq_q     <= '0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          tlcd_pkg::REG_WINDOW:   window_q   <= cfg_data_i[tlcd_pkg::WINDOW_BITS-1:0];
          tlcd_pkg::REG_PATIENCE: patience_q <= cfg_data_i[HB-1:0];
          default: ;
        endcase
      end
      wp_q     <= wp_d;
      fill_q   <= fill_d;
      hits_q   <= hits_d;
      remain_q <= remain_d;
      rd_vld_q <= cmd_i.issue_read;
      uniq_q   <= uniq_d;
      if (cmd_i.accept) begin
        checked_q <= checked_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_addr_q <= rd_addr_d;
    first_q   <= first_d;
    second_q  <= second_d;
    if (cmd_i.accept) begin
      mem[wp_eff] <= in_word_i.token_id;
    end
    if (cmd_i.issue_read) begin
      rd_data_q <= mem[rd_addr_q];
    end
    if (cmd_i.load_out) begin
      out_q.stop           <= checked_q && (hits_new >= patience_q);
      out_q.distinct_seen  <= checked_q ? uniq_q : 2'd0;
      out_q.window_checked <= checked_q;
      out_q.hits           <= hits_new;
    end
  end

  assign sts_o.checked   = checked_q;
  assign sts_o.last_read = (remain_q == CNT_W'(1));
  assign out_word_o      = out_q;

endmodule

>>> design/tlcd_ctrl.sv
// sequencer for accept, window scan and result hand-off
module tlcd_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  input  tlcd_pkg::ctrl_sts_t sts_i,
  output tlcd_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d          = state_q;
    cmd_o.accept     = 1'b0;
    cmd_o.issue_read = 1'b0;
    cmd_o.load_out   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (!sts_i.checked) begin
          state_d = ST_DONE;
        end else begin
          cmd_o.issue_read = 1'b1;
          if (sts_i.last_read) begin
            state_d = ST_DRAIN;
          end
        end
      end
      // last read word is compared here
      ST_DRAIN: state_d = ST_DONE;
      ST_DONE: begin
        if (out_free) begin
          cmd_o.load_out = 1'b1;
          state_d        = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o  = (state_q != ST_IDLE);
  assign out_valid_o = out_valid_q;

endmodule

>>> design/token_loop_collapse_detector.sv
// top level of the token loop collapse detector
//
//   channel | direction | handshake                  | payload
//   in      | input     | in_valid_i / in_stall_o    | in_word_i  (token_id, sequence_start)
//   out     | output    | out_valid_o / out_stall_i  | out_word_o (stop, distinct_seen,
//           |           |                            |   window_checked, hits)
//   cfg     | input     | cfg_we_i                   | cfg_idx_i, cfg_data_i
//
// a word is accepted, then its checked window of w tokens (w capped at MAX_WINDOW) is read
// in turn through the single read port of the history memory; an unchecked word skips them
// reset clears pointer, fill count, hit count and config registers; history needs no clearing
// the next word is taken while a result waits in the output register
// a stalled output holds the scan in its final state until the result is taken
module token_loop_collapse_detector #(
  parameter int MAX_WINDOW = tlcd_pkg::MAX_WINDOW_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               cfg_we_i,
  input  logic [tlcd_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [tlcd_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  tlcd_pkg::in_word_t                 in_word_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output tlcd_pkg::out_word_t                out_word_o
);

  tlcd_pkg::ctrl_cmd_t cmd;
  tlcd_pkg::ctrl_sts_t sts;

  tlcd_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  tlcd_datapath #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_word_i  (in_word_i),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .out_word_o (out_word_o)
  );

endmodule
